// ----- rtl/assert_macros.svh -----
// Assertion helpers for the thread scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check an implication whose consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/tlts_pkg.sv -----
`timescale 1ns / 1ps
package tlts_pkg;
    localparam int DefSlots   = 16;
    localparam int OpW        = 3;
    localparam int StatusW    = 2;
    localparam int OutSlotW   = 4;
    localparam logic [7:0] QuantumReset = 8'd10;

    typedef enum logic [OpW-1:0] {
        OP_CREATE = 3'd0,
        OP_TICK   = 3'd1,
        OP_READ   = 3'd2,
        OP_DONE   = 3'd3,
        OP_EXIT   = 3'd4
    } t_op;

    localparam logic [StatusW-1:0] ST_OK     = 2'd0;
    localparam logic [StatusW-1:0] ST_NOSLOT = 2'd1;
    localparam logic [StatusW-1:0] ST_FINISH = 2'd2;

    typedef enum logic [1:0] {
        Q_LOW  = 2'd0,
        Q_HIGH = 2'd1,
        Q_WAIT = 2'd2
    } t_qid;
endpackage

// ----- rtl/tlts_queue.sv -----
`timescale 1ns / 1ps
// FIFO of slot numbers in a synchronous memory. The head entry is prefetched
// into a register so a pop is served in the same cycle it is asked for.
module tlts_queue #(
    parameter int SLOTS = 16,
    parameter int SW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [SW-1:0] i_push_slot,
    input  logic          i_pop,
    output logic [SW-1:0] o_head,
    output logic          o_empty
);
    localparam int CW = $clog2(SLOTS + 1);

    logic [SW-1:0] r_mem [SLOTS];
    logic [SW-1:0] r_head_q, r_tail_q;
    logic [SW-1:0] n_head_q, n_tail_q;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_rd;
    logic          r_fwd;
    logic [SW-1:0] r_fwd_slot;
    logic          do_push;

    assign do_push = i_push && (r_cnt < CW'(SLOTS) || i_pop);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_fwd ? r_fwd_slot : r_rd;

    always_comb begin
        n_head_q = r_head_q;
        n_tail_q = r_tail_q;
        n_cnt    = r_cnt;
        if (i_pop && !o_empty) begin
            n_head_q = (r_head_q == SW'(SLOTS - 1)) ? '0 : r_head_q + 1'b1;
            n_cnt    = n_cnt - 1'b1;
        end
        if (do_push) begin
            n_tail_q = (r_tail_q == SW'(SLOTS - 1)) ? '0 : r_tail_q + 1'b1;
            n_cnt    = n_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_tail_q] <= i_push_slot;
        r_rd <= r_mem[n_head_q];
        // Forward a write landing on the entry that becomes the head.
        r_fwd      <= do_push && (r_tail_q == n_head_q);
        r_fwd_slot <= i_push_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_q <= '0;
            r_tail_q <= '0;
            r_cnt    <= '0;
        end else begin
            r_head_q <= n_head_q;
            r_tail_q <= n_tail_q;
            r_cnt    <= n_cnt;
        end
    end
endmodule

// ----- rtl/two_level_thread_scheduler.sv -----
`timescale 1ns / 1ps
// Channel | valid    | stall    | payload
// in      | i_valid  | o_stall  | i_opcode i_new_priority i_page_cached
// out     | o_valid  | i_stall  | o_running_thread .. o_status
// cfg     | i_cfg_we | -        | i_cfg_data (quantum length in timer ticks)
// The queue heads sit prefetched in registers, so each beat is decided and its
// result registered at the edge it is accepted.
// A new beat is taken whenever the output register is empty or drains.
// Reset (synchronous, active low) leaves slot 0 running and all queues empty.
// An output stall holds the result and stalls the input.
module two_level_thread_scheduler #(
    parameter int THREAD_SLOTS = tlts_pkg::DefSlots
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [tlts_pkg::OpW-1:0]      i_opcode,
    input  logic                          i_new_priority,
    input  logic                          i_page_cached,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tlts_pkg::OutSlotW-1:0] o_running_thread,
    output logic                          o_running_is_idle,
    output logic                          o_switched,
    output logic [tlts_pkg::OutSlotW-1:0] o_created_thread,
    output logic [tlts_pkg::StatusW-1:0]  o_status,
    input  logic                          i_cfg_we,
    input  logic [7:0]                    i_cfg_data
);
    import tlts_pkg::*;
    `include "assert_macros.svh"
    localparam int SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;

    logic [7:0] r_quantum;
    logic [THREAD_SLOTS-1:0] r_used, n_used, r_prio, n_prio;
    logic [SW-1:0] r_cur, n_cur;
    logic r_idle, n_idle, r_done, n_done;
    logic [7:0] r_ticks, n_ticks;

    logic [2:0] push, pop;
    logic [SW-1:0] push_slot [3];
    logic [SW-1:0] head [3];
    logic [2:0] empty;

    for (genvar q = 0; q < 3; q++) begin : g_q
        tlts_queue #(.SLOTS(THREAD_SLOTS), .SW(SW)) u_q (
            .i_clk, .i_rst_n,
            .i_push(push[q]), .i_push_slot(push_slot[q]),
            .i_pop(pop[q]), .o_head(head[q]), .o_empty(empty[q])
        );
    end

    logic accept, run_low, free_found;
    logic [SW-1:0] free_slot;
    logic [7:0] qload;
    logic [SW-1:0] rdy;
    logic [StatusW-1:0] status;
    logic [SW-1:0] created;
    // queue occupancy as it stands before this beat
    logic hi_avail, lo_avail, wt_avail;

    assign o_stall = o_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign run_low = !r_idle && !r_prio[r_cur];
    assign qload   = (r_quantum == 8'd0) ? 8'd1 : r_quantum;

    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_slot  = SW'(i);
            end
        end
    end

    always_comb begin
        n_used = r_used; n_prio = r_prio; n_cur = r_cur; n_idle = r_idle;
        n_done = r_done; n_ticks = r_ticks;
        push = '0; pop = '0;
        push_slot[Q_LOW] = r_cur; push_slot[Q_HIGH] = '0; push_slot[Q_WAIT] = r_cur;
        status = ST_OK; created = '0; rdy = head[Q_WAIT];
        hi_avail = !empty[Q_HIGH]; lo_avail = !empty[Q_LOW]; wt_avail = !empty[Q_WAIT];
        if (r_done) begin
            status = ST_FINISH;
        end else begin
            case (i_opcode)
                OP_CREATE: begin
                    if (!free_found) begin
                        status = ST_NOSLOT;
                    end else begin
                        created = free_slot;
                        n_used[free_slot] = 1'b1;
                        n_prio[free_slot] = i_new_priority;
                        if (run_low && i_new_priority) begin
                            push[Q_LOW] = 1'b1;
                            n_cur = free_slot;
                            n_ticks = qload;
                        end else if (i_new_priority) begin
                            push[Q_HIGH] = 1'b1; push_slot[Q_HIGH] = free_slot;
                        end else begin
                            push[Q_LOW] = 1'b1; push_slot[Q_LOW] = free_slot;
                        end
                    end
                end
                OP_TICK: begin
                    if (run_low) begin
                        if (r_ticks <= 8'd1) begin
                            n_ticks = qload;
                            if (hi_avail) begin
                                push[Q_LOW] = 1'b1; pop[Q_HIGH] = 1'b1; n_cur = head[Q_HIGH];
                            end else if (lo_avail) begin
                                push[Q_LOW] = 1'b1; pop[Q_LOW] = 1'b1; n_cur = head[Q_LOW];
                            end
                        end else begin
                            n_ticks = r_ticks - 1'b1;
                        end
                    end
                end
                OP_READ: begin
                    if (!r_idle && !i_page_cached) begin
                        push[Q_WAIT] = 1'b1;
                        n_ticks = qload;
                        if (hi_avail) begin
                            pop[Q_HIGH] = 1'b1; n_cur = head[Q_HIGH];
                        end else if (lo_avail) begin
                            pop[Q_LOW] = 1'b1; n_cur = head[Q_LOW];
                        end else begin
                            n_idle = 1'b1;
                        end
                    end
                end
                OP_DONE: begin
                    if (wt_avail) begin
                        pop[Q_WAIT] = 1'b1;
                        if (r_prio[rdy] && run_low) begin
                            push[Q_LOW] = 1'b1;
                            n_cur = rdy; n_ticks = qload;
                        end else if (r_idle) begin
                            // Queue the woken thread, then pick high first, then low.
                            n_idle = 1'b0; n_ticks = qload;
                            if (hi_avail) begin
                                pop[Q_HIGH] = 1'b1; n_cur = head[Q_HIGH];
                                if (r_prio[rdy]) begin
                                    push[Q_HIGH] = 1'b1; push_slot[Q_HIGH] = rdy;
                                end else begin
                                    push[Q_LOW] = 1'b1; push_slot[Q_LOW] = rdy;
                                end
                            end else if (!r_prio[rdy] && lo_avail) begin
                                pop[Q_LOW] = 1'b1; n_cur = head[Q_LOW];
                                push[Q_LOW] = 1'b1; push_slot[Q_LOW] = rdy;
                            end else begin
                                n_cur = rdy;
                            end
                        end else if (r_prio[rdy]) begin
                            push[Q_HIGH] = 1'b1; push_slot[Q_HIGH] = rdy;
                        end else begin
                            push[Q_LOW] = 1'b1; push_slot[Q_LOW] = rdy;
                        end
                    end
                end
                OP_EXIT: begin
                    if (!r_idle) begin
                        n_used[r_cur] = 1'b0;
                        n_ticks = qload;
                        if (hi_avail) begin
                            pop[Q_HIGH] = 1'b1; n_cur = head[Q_HIGH];
                        end else if (lo_avail) begin
                            pop[Q_LOW] = 1'b1; n_cur = head[Q_LOW];
                        end else if (wt_avail) begin
                            n_idle = 1'b1;
                        end else begin
                            n_ticks = r_ticks;
                            n_done = 1'b1; status = ST_FINISH;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (!accept) begin
            push = '0; pop = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QuantumReset;
            r_used <= THREAD_SLOTS'(1);
            r_prio <= '0;
            r_cur <= '0; r_idle <= 1'b0; r_done <= 1'b0;
            r_ticks <= QuantumReset;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_quantum <= i_cfg_data;
            if (accept) begin
                r_used <= n_used; r_prio <= n_prio; r_cur <= n_cur;
                r_idle <= n_idle; r_done <= n_done; r_ticks <= n_ticks;
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_running_thread  <= (n_done || n_idle) ? '0 : OutSlotW'(n_cur);
            o_running_is_idle <= n_idle && !n_done;
            o_switched        <= !n_done && ((n_idle != r_idle) ||
                                 (!n_idle && n_cur != r_cur) ||
                                 (i_opcode == OP_EXIT && !r_idle));
            o_created_thread  <= n_done ? '0 : OutSlotW'(created);
            o_status          <= status;
        end
    end

    `CHK_IMPL(a_no_idle_done, i_clk, i_rst_n, r_done, !r_idle, "idle while finished")
    `CHK_IMPL(a_slot_used, i_clk, i_rst_n, !r_idle && !r_done, r_used[r_cur], "running slot free")
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped")
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import tlts_pkg::*;

    localparam int Slots     = 16;
    localparam int IdleLimit = 5000;
    localparam int LongHold  = 200;

    // Opcodes the block does not decode; they must answer status ok
    localparam logic [OpW-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OpW-1:0] OP_RSVD7 = 3'd7;

    typedef struct packed {
        logic [OutSlotW-1:0] running;
        logic                is_idle;
        logic                switched;
        logic [OutSlotW-1:0] created;
        logic [StatusW-1:0]  status;
    } sched_result_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [OpW-1:0]      i_opcode;
    logic                i_new_priority;
    logic                i_page_cached;
    logic                o_valid;
    logic                i_stall;
    logic [OutSlotW-1:0] o_running_thread;
    logic                o_running_is_idle;
    logic                o_switched;
    logic [OutSlotW-1:0] o_created_thread;
    logic [StatusW-1:0]  o_status;
    logic                i_cfg_we;
    logic [7:0]          i_cfg_data;

    two_level_thread_scheduler i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_new_priority   (i_new_priority),
        .i_page_cached    (i_page_cached),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_running_thread (o_running_thread),
        .o_running_is_idle(o_running_is_idle),
        .o_switched       (o_switched),
        .o_created_thread (o_created_thread),
        .o_status         (o_status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Scheduler shadow state, updated once per accepted input beat
    // ------------------------------------------------------------------
    logic [7:0]          quantum;
    logic                slot_busy [Slots];
    logic                slot_high [Slots];
    logic [3:0]          ready_store [3][Slots];
    int                  q_head [3];
    int                  q_tail [3];
    int                  q_count [3];
    logic [3:0]          cur_slot;
    logic                idle_on;
    logic [7:0]          ticks;
    logic                finished;

    sched_result_t       expected_results [$];
    int                  fail_count;
    bit                  quiet;        // no gaps and no stalls while set
    bit                  hold_req;     // asks the receiver for a long hold

    task automatic reset_shadow();
        quantum = QuantumReset;
        for (int i = 0; i < Slots; i++) begin
            slot_busy[i] = 1'b0;
            slot_high[i] = 1'b0;
        end
        slot_busy[0] = 1'b1;
        for (int q = 0; q < 3; q++) begin
            q_head[q]  = 0;
            q_tail[q]  = 0;
            q_count[q] = 0;
        end
        cur_slot = '0;
        idle_on  = 1'b0;
        ticks    = QuantumReset;
        finished = 1'b0;
    endtask

    task automatic enqueue(input int q, input logic [3:0] slot);
        if (q_count[q] < Slots) begin
            ready_store[q][q_tail[q]] = slot;
            q_tail[q] = (q_tail[q] + 1) % Slots;
            q_count[q]++;
        end
    endtask

    task automatic dequeue(input int q, output logic [3:0] slot);
        slot = '0;
        if (q_count[q] != 0) begin
            slot = ready_store[q][q_head[q]];
            q_head[q] = (q_head[q] + 1) % Slots;
            q_count[q]--;
        end
    endtask

    // High first, then low, then idle while something waits on the disk
    task automatic dispatch_next(output bit found);
        found = 1'b1;
        if (q_count[Q_HIGH] != 0) begin
            dequeue(Q_HIGH, cur_slot);
            idle_on = 1'b0;
        end else if (q_count[Q_LOW] != 0) begin
            dequeue(Q_LOW, cur_slot);
            idle_on = 1'b0;
        end else if (q_count[Q_WAIT] != 0) begin
            idle_on = 1'b1;
        end else begin
            found = 1'b0;
        end
        if (found) ticks = quantum;
    endtask

    function automatic bit low_running();
        return !idle_on && !slot_high[cur_slot];
    endfunction

    task automatic schedule_event(input logic [OpW-1:0] op, input logic prio,
                                  input logic cached, output sched_result_t r);
        logic [3:0] old_slot;
        logic       old_idle;
        logic [3:0] created;
        logic [3:0] woken;
        logic [StatusW-1:0] st;
        int         free_idx;
        bit         found;

        old_slot = cur_slot;
        old_idle = idle_on;
        created  = '0;
        st       = ST_OK;
        if (finished) begin
            st = ST_FINISH;
        end else if (op == OP_CREATE) begin
            free_idx = -1;
            for (int i = Slots - 1; i >= 0; i--) if (!slot_busy[i]) free_idx = i;
            if (free_idx < 0) begin
                st = ST_NOSLOT;
            end else begin
                created = free_idx[3:0];
                slot_busy[free_idx] = 1'b1;
                slot_high[free_idx] = prio;
                if (low_running() && prio) begin
                    // preempt: running low thread back to the round-robin tail
                    enqueue(Q_LOW, cur_slot);
                    cur_slot = created;
                    ticks    = quantum;
                end else if (prio) begin
                    enqueue(Q_HIGH, created);
                end else begin
                    enqueue(Q_LOW, created);
                end
            end
        end else if (op == OP_TICK) begin
            if (low_running()) begin
                if (ticks <= 8'd1) begin
                    enqueue(Q_LOW, cur_slot);
                    dispatch_next(found);
                end else begin
                    ticks--;
                end
            end
        end else if (op == OP_READ) begin
            if (!idle_on && !cached) begin
                enqueue(Q_WAIT, cur_slot);
                dispatch_next(found);
            end
        end else if (op == OP_DONE) begin
            if (q_count[Q_WAIT] != 0) begin
                dequeue(Q_WAIT, woken);
                if (slot_high[woken]) begin
                    if (low_running()) begin
                        enqueue(Q_LOW, cur_slot);
                        cur_slot = woken;
                        ticks    = quantum;
                    end else begin
                        enqueue(Q_HIGH, woken);
                    end
                end else begin
                    enqueue(Q_LOW, woken);
                end
                if (idle_on) dispatch_next(found);
            end
        end else if (op == OP_EXIT) begin
            if (!idle_on) begin
                slot_busy[cur_slot] = 1'b0;
                dispatch_next(found);
                if (!found) begin
                    finished = 1'b1;
                    idle_on  = 1'b0;
                end
            end
        end

        if (finished) begin
            r = '{running: '0, is_idle: 1'b0, switched: 1'b0, created: '0,
                  status: ST_FINISH};
        end else begin
            r.running  = idle_on ? '0 : cur_slot;
            r.is_idle  = idle_on;
            r.switched = (idle_on != old_idle) || (!idle_on && cur_slot != old_slot)
                         || (op == OP_EXIT && !old_idle);
            r.created  = created;
            r.status   = st;
        end
    endtask

    // True when an exit now would leave nothing at all
    function automatic bit exit_ends_all();
        return !idle_on && q_count[Q_HIGH] == 0 && q_count[Q_LOW] == 0
               && q_count[Q_WAIT] == 0;
    endfunction

    // ------------------------------------------------------------------
    // Drive and check
    // ------------------------------------------------------------------
    task automatic send_event(input logic [OpW-1:0] op, input logic prio,
                              input logic cached);
        int gap;
        sched_result_t r;
        gap = quiet ? 0 : $urandom_range(0, 12);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_opcode       <= op;
        i_new_priority <= prio;
        i_page_cached  <= cached;
        i_valid        <= 1'b1;
        // hold the beat until the block takes it
        do @(posedge i_clk); while (o_stall);
        schedule_event(op, prio, cached, r);
        expected_results.push_back(r);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_quantum(input logic [7:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        quantum = value;
    endtask

    always @(posedge i_clk) begin
        sched_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_running_thread !== want.running) begin
                    $error("running_thread exp %0d got %0d", want.running, o_running_thread);
                    fail_count++;
                end
                if (o_running_is_idle !== want.is_idle) begin
                    $error("running_is_idle exp %0d got %0d", want.is_idle,
                           o_running_is_idle);
                    fail_count++;
                end
                if (o_switched !== want.switched) begin
                    $error("switched exp %0d got %0d", want.switched, o_switched);
                    fail_count++;
                end
                if (o_created_thread !== want.created) begin
                    $error("created_thread exp %0d got %0d", want.created, o_created_thread);
                    fail_count++;
                end
                if (o_status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, o_status);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: a random stall after each beat, or a long hold on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LongHold;
            end
            if (o_valid && !i_stall && stall_left == 0)
                stall_left = quiet ? 0 : $urandom_range(0, 12);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: too long without any beat on either channel
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // lone low thread: the tick counts down the quantum left from reset
        set_quantum(8'd1);
        send_event(OP_TICK, 1'b0, 1'b0);
        // low create queues, high create preempts slot 0
        send_event(OP_CREATE, 1'b0, 1'b0);
        send_event(OP_CREATE, 1'b1, 1'b0);
        send_event(OP_TICK, 1'b0, 1'b0);
        send_event(OP_EXIT, 1'b0, 1'b0);
        send_event(OP_TICK, 1'b0, 1'b0);
        send_event(OP_TICK, 1'b0, 1'b0);
        // cached read does nothing; two real reads leave only the idle thread
        send_event(OP_READ, 1'b0, 1'b1);
        send_event(OP_READ, 1'b0, 1'b0);
        send_event(OP_READ, 1'b1, 1'b0);
        send_event(OP_TICK, 1'b0, 1'b0);
        send_event(OP_READ, 1'b0, 1'b0);
        send_event(OP_EXIT, 1'b0, 1'b0);
        // high create while idle: no preemption
        send_event(OP_CREATE, 1'b1, 1'b1);
        send_event(OP_DONE, 1'b0, 1'b0);
        send_event(OP_DONE, 1'b0, 1'b0);
        send_event(OP_DONE, 1'b0, 1'b0);
        send_event(OP_RSVD5, 1'b1, 1'b1);
        send_event(OP_RSVD7, 1'b0, 1'b0);
        // quantum zero acts like one; the running thread is high, so these ticks change nothing
        set_quantum(8'd0);
        send_event(OP_TICK, 1'b0, 1'b0);
        send_event(OP_TICK, 1'b0, 1'b0);
    endtask

    task automatic random_event();
        int pick;
        logic [OpW-1:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 28) op = OP_CREATE;
        else if (pick < 52) op = OP_TICK;
        else if (pick < 67) op = OP_READ;
        else if (pick < 82) op = OP_DONE;
        else if (pick < 96) op = OP_EXIT;
        else op = OpW'($urandom_range(5, 7));
        // keep the scheduler alive until the final test
        if (op == OP_EXIT && exit_ends_all()) op = OP_CREATE;
        send_event(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_random(input logic [7:0] q_val, input int count);
        set_quantum(q_val);
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
            random_event();
        end
    endtask

    task automatic test_backpressure();
        quiet = 1'b0;
        drain();
        hold_req = 1'b1;
        for (int n = 0; n < 30; n++) random_event();
        // sender waits for a full drain before going on
        drain();
        for (int n = 0; n < 20; n++) random_event();
    endtask

    task automatic test_finish();
        quiet = 1'b0;
        while (!finished) begin
            if (idle_on) send_event(OP_DONE, 1'b0, 1'b0);
            else send_event(OP_EXIT, 1'b0, 1'b0);
        end
        send_event(OP_CREATE, 1'b1, 1'b0);
        send_event(OP_TICK, 1'b0, 1'b0);
        send_event(OP_READ, 1'b0, 1'b0);
        send_event(OP_DONE, 1'b0, 1'b0);
        send_event(OP_EXIT, 1'b0, 1'b0);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_opcode       = OP_CREATE;
        i_new_priority = 1'b0;
        i_page_cached  = 1'b0;
        i_stall        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = 8'd0;
        fail_count     = 0;
        quiet          = 1'b0;
        hold_req       = 1'b0;
        reset_shadow();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(8'd3, 250);
        test_backpressure();
        test_random(8'd255, 200);
        test_random(8'd1, 150);
        test_random(8'd10, 150);
        test_finish();

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
